[design/apq_pkg.sv]
// Package with shared types, codes and defaults of the array priority queue.
package apq_pkg;

  localparam int DEPTH_DEF     = 8;
  localparam int PRIO_BITS_DEF = 4;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic       req_type;
    logic [3:0] priority_req;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] removed_value;
    logic [3:0] occupancy;
  } out_word_t;

  // Commands broadcast from the sequencer to every cell.
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

endpackage

[design/apq_cell.sv]
// One queue cell: holds an entry and forwards the running maximum to its neighbor.
module apq_cell #(
  parameter int DEPTH = 8,
  parameter int PW    = 4,
  parameter int IDX   = 0,
  localparam int CW   = $clog2(DEPTH + 1),
  localparam int IW   = $clog2(DEPTH)
) (
  input  logic                clk,
  input  apq_pkg::cell_ctrl_t ctrl,
  input  logic [CW-1:0]       count,
  input  logic [IW-1:0]       where,
  input  logic [PW-1:0]       load_value,
  input  logic [PW-1:0]       next_value,
  input  logic [PW-1:0]       best_in,
  input  logic [IW-1:0]       where_in,
  output logic [PW-1:0]       entry,
  output logic [PW-1:0]       best_out,
  output logic [IW-1:0]       where_out
);
  import apq_pkg::*;

  localparam logic [CW-1:0] IDX_C = CW'(IDX);
  localparam logic [IW-1:0] IDX_W = IW'(IDX);

  logic [PW-1:0] entry_r;
  logic [PW-1:0] entry_nxt;
  logic [PW-1:0] best_r;
  logic [PW-1:0] best_nxt;
  logic [IW-1:0] where_r;
  logic [IW-1:0] where_nxt;
  logic          occupied;
  logic          take;

  assign occupied = IDX_C < count;
  // The first cell always wins when occupied; later cells win only on a strictly greater
  // value, which keeps the oldest of equal maxima.
  assign take = occupied && ((IDX == 0) || (entry_r > best_in));

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.load && (IDX_C == count)) begin
      entry_nxt = load_value;
    end else if (ctrl.shift && (IDX_W >= where) && ((IDX_C + CW'(1)) < count)) begin
      entry_nxt = next_value;
    end
    best_nxt  = take ? entry_r : best_in;
    where_nxt = take ? IDX_W : where_in;
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    best_r  <= best_nxt;
    where_r <= where_nxt;
  end

  assign entry     = entry_r;
  assign best_out  = best_r;
  assign where_out = where_r;

endmodule

[design/array_priority_queue_extract_max_top.sv]
// Top level of the array priority queue with extract-max, built as a chain of cells.
//
// Usage: a request word is taken on in_data at a rising edge where start is high and
// busy is low. Field req_type selects insert or remove; priority_req is the value
// that an insert appends at the tail of the queue.
// Every request gives exactly one result word on out_data, shown for one cycle with
// out_valid high. The receiver cannot stall; a result is simply taken that cycle.
// Throughput: an insert, or a remove from an empty queue, gives its result in the cycle
// after acceptance and busy stays low, so such requests can follow every cycle. A
// successful remove keeps busy high while the running maximum travels through the
// DEPTH registered cells, one cell per cycle; its result appears as busy goes low, and
// the next request can be taken in that same cycle. The length of the cell chain sets
// how long busy stays high.
// The queue entries close the gap of a removed entry by a parallel shift.
// Reset clears the fill count, the sequencer and the result strobe; the entry storage
// is not cleared, since only entries below the fill count are ever looked at.
module array_priority_queue_extract_max_top #(
  parameter int DEPTH         = apq_pkg::DEPTH_DEF,
  parameter int PRIORITY_BITS = apq_pkg::PRIO_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  apq_pkg::in_word_t  in_data,
  output logic               out_valid,
  output apq_pkg::out_word_t out_data
);
  import apq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int PW = PRIORITY_BITS;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

  state_t        state_r;
  state_t        state_nxt;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic [IW-1:0] scan_cnt_r;
  logic [IW-1:0] scan_cnt_nxt;
  logic          out_valid_r;
  logic          out_valid_nxt;
  out_word_t     out_data_r;
  out_word_t     out_data_nxt;
  cell_ctrl_t    ctrl;
  logic          accept;
  logic [PW-1:0] load_value;

  // Chain wiring: element i feeds cell i, element DEPTH is the tail of the chain.
  logic [PW-1:0] entry_w [DEPTH];
  logic [PW-1:0] best_w  [DEPTH+1];
  logic [IW-1:0] where_w [DEPTH+1];

  assign best_w[0]  = '0;
  assign where_w[0] = '0;
  assign load_value = PW'(in_data.priority_req);
  assign accept     = start && (state_r == ST_IDLE);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [PW-1:0] next_value;
    if (i == DEPTH - 1) begin : g_tail
      assign next_value = entry_w[i];
    end else begin : g_mid
      assign next_value = entry_w[i+1];
    end
    apq_cell #(
      .DEPTH (DEPTH),
      .PW    (PW),
      .IDX   (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .count      (count_r),
      .where      (where_w[DEPTH]),
      .load_value (load_value),
      .next_value (next_value),
      .best_in    (best_w[i]),
      .where_in   (where_w[i]),
      .entry      (entry_w[i]),
      .best_out   (best_w[i+1]),
      .where_out  (where_w[i+1])
    );
  end

  // Sequencer: inserts and empty removes finish at once; a remove waits for the
  // running maximum to leave the last cell, then shifts the gap closed.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    scan_cnt_nxt  = scan_cnt_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    ctrl          = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_data_nxt.removed_value = '0;
          if (in_data.req_type == REQ_INSERT) begin
            out_valid_nxt = 1'b1;
            if (count_r >= FULL_CNT) begin
              out_data_nxt.status = STATUS_FULL;
            end else begin
              ctrl.load           = 1'b1;
              count_nxt           = count_r + CW'(1);
              out_data_nxt.status = STATUS_DONE;
            end
            out_data_nxt.occupancy = 4'(count_nxt);
          end else if (count_r == '0) begin
            out_valid_nxt          = 1'b1;
            out_data_nxt.status    = STATUS_EMPTY;
            out_data_nxt.occupancy = 4'(count_r);
          end else begin
            state_nxt    = ST_SCAN;
            scan_cnt_nxt = '0;
          end
        end
      end
      ST_SCAN: begin
        if (scan_cnt_r == LAST_IDX) begin
          ctrl.shift                 = 1'b1;
          count_nxt                  = count_r - CW'(1);
          out_valid_nxt              = 1'b1;
          out_data_nxt.status        = STATUS_DONE;
          out_data_nxt.removed_value = 4'(best_w[DEPTH]);
          out_data_nxt.occupancy     = 4'(count_nxt);
          state_nxt                  = ST_IDLE;
        end else begin
          scan_cnt_nxt = scan_cnt_r + IW'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      scan_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("fill count above depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.req_type == REQ_INSERT) && (count_r < FULL_CNT))
    |=> (count_r == $past(count_r) + CW'(1)) && out_valid)
    else $error("insert did not grow the queue");

  a_remove_done: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SCAN) && (scan_cnt_r == LAST_IDX))
    |=> out_valid && !busy && (count_r == $past(count_r) - CW'(1)))
    else $error("remove did not finish as expected");

  a_no_result_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while scanning");
`endif

endmodule

[tb/array_priority_queue_extract_max_top_test.sv]
// Self-checking testbench for the array priority queue with extract-max.
`timescale 1ns / 100ps

module array_priority_queue_extract_max_top_test;
  import apq_pkg::*;

  localparam int DEPTH      = DEPTH_DEF;
  localparam int PRIO_BITS  = PRIO_BITS_DEF;
  localparam int RAND_WORDS = 500;
  // An idle stretch is at most one sender gap plus one full scan of the cell chain.
  // The limit is that figure taken many times over.
  localparam int IDLE_LIMIT = 200;
  localparam int MAX_SHOWN  = 10;

  // Traffic mixes of the random part. Filling and draining phases push the queue
  // against both of its walls, so full and empty cases come up often.
  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_CHURN
  } mix_t;

  // One row of the directed table. Where typed is set, want is the result
  // word written by hand; otherwise the predictor supplies it.
  typedef struct {
    in_word_t  word;
    bit        typed;
    out_word_t want;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_data;
  logic      out_valid;
  out_word_t out_data;

  array_priority_queue_extract_max_top #(
    .DEPTH         (DEPTH),
    .PRIORITY_BITS (PRIO_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // The predictor keeps its own copy of the queue, oldest value at index 0.
  logic [PRIO_BITS-1:0] held_prio[$];
  out_word_t            pending_results[$];

  // Side information for the word now on in_data, read at the edge that takes it.
  bit        row_typed;
  out_word_t row_want;

  int        err_count;
  int        idle_run;
  out_word_t predicted;
  out_word_t want_word;
  dir_row_t  dir_rows[$];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Works out the result word of one request and updates the predicted queue.
  // A remove scans for the greatest value; the strict compare keeps the oldest
  // of several equal maxima. Deleting it closes the gap in arrival order.
  function automatic out_word_t apply_request(in_word_t w);
    out_word_t r;
    int        best_pos;
    r.status        = STATUS_DONE;
    r.removed_value = '0;
    if (w.req_type == REQ_INSERT) begin
      if (held_prio.size() >= DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        held_prio.push_back(w.priority_req[PRIO_BITS-1:0]);
      end
    end else if (held_prio.size() == 0) begin
      r.status = STATUS_EMPTY;
    end else begin
      best_pos = 0;
      for (int k = 1; k < held_prio.size(); k++) begin
        if (held_prio[k] > held_prio[best_pos]) begin
          best_pos = k;
        end
      end
      r.removed_value = 4'(held_prio[best_pos]);
      held_prio.delete(best_pos);
    end
    r.occupancy = 4'(held_prio.size());
    return r;
  endfunction

  function automatic dir_row_t mk_row(logic rt, logic [3:0] v, bit typed,
                                      logic [1:0] st, logic [3:0] rv, logic [3:0] occ);
    dir_row_t r;
    r.word.req_type      = rt;
    r.word.priority_req  = v;
    r.typed              = typed;
    r.want.status        = st;
    r.want.removed_value = rv;
    r.want.occupancy     = occ;
    return r;
  endfunction

  // Presents one word at the falling edge and holds it until an edge where busy
  // is low takes it. Start stays high across back-to-back words, so it is never
  // lowered and raised within one time step. Returns at the next falling edge.
  task automatic send_word(in_word_t w, bit typed, out_word_t want);
    start     = 1'b1;
    in_data   = w;
    row_typed = typed;
    row_want  = want;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Monitor: at every rising edge, record the word taken and check the result word
  // shown. Both are sampled before the block's own updates of that edge land.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        predicted = apply_request(in_data);
        if (row_typed) begin
          pending_results.push_back(row_want);
        end else begin
          pending_results.push_back(predicted);
        end
      end
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          if (err_count < MAX_SHOWN) begin
            $display("%0t: result word with none expected: status=%0d removed=%0d occ=%0d",
                     $realtime, out_data.status, out_data.removed_value, out_data.occupancy);
          end
          err_count++;
        end else begin
          want_word = pending_results.pop_front();
          if (out_data.status !== want_word.status ||
              out_data.removed_value !== want_word.removed_value ||
              out_data.occupancy !== want_word.occupancy) begin
            if (err_count < MAX_SHOWN) begin
              $display("%0t: mismatch: expected status=%0d removed=%0d occ=%0d, got %0d %0d %0d",
                       $realtime, want_word.status, want_word.removed_value,
                       want_word.occupancy, out_data.status, out_data.removed_value,
                       out_data.occupancy);
            end
            err_count++;
          end
        end
      end
      if ((start && !busy) || out_valid) begin
        idle_run = 0;
      end else begin
        idle_run++;
      end
    end
  end

  // Watchdog: a stretch this long with no word moving in either direction means
  // the block is stuck or a result word went missing.
  initial begin
    idle_run = 0;
    @(posedge rst_n);
    while (idle_run < IDLE_LIMIT) @(posedge clk);
    $display("array_priority_queue_extract_max_top_test: FAIL");
    $finish;
  end

  initial begin
    in_word_t  w;
    out_word_t no_want;
    mix_t      mix;
    int        mix_left;
    int        burst_left;
    int        gap;
    int        pct;
    int        sel;
    bit        go_insert;

    // Every input is known from time zero; reset is held low at first and then released.
    err_count = 0;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    row_typed = 1'b0;
    row_want  = '0;
    no_want   = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed part: empty queue right after reset, the two extreme values, a full
    // queue with dropped inserts, ties among equal maxima, and draining to empty.
    dir_rows.push_back(mk_row(REQ_REMOVE, 4'd9,  1'b1, STATUS_EMPTY, 4'd0,  4'd0));
    dir_rows.push_back(mk_row(REQ_INSERT, 4'd0,  1'b1, STATUS_DONE,  4'd0,  4'd1));
    dir_rows.push_back(mk_row(REQ_INSERT, 4'd15, 1'b1, STATUS_DONE,  4'd0,  4'd2));
    dir_rows.push_back(mk_row(REQ_REMOVE, 4'd0,  1'b1, STATUS_DONE,  4'd15, 4'd1));
    dir_rows.push_back(mk_row(REQ_REMOVE, 4'd15, 1'b1, STATUS_DONE,  4'd0,  4'd0));
    dir_rows.push_back(mk_row(REQ_REMOVE, 4'd0,  1'b1, STATUS_EMPTY, 4'd0,  4'd0));
    dir_rows.push_back(mk_row(REQ_INSERT, 4'd7,  1'b0, STATUS_DONE,  4'd0,  4'd0));
    dir_rows.push_back(mk_row(REQ_INSERT, 4'd9,  1'b0, STATUS_DONE,  4'd0,  4'd0));
    dir_rows.push_back(mk_row(REQ_INSERT, 4'd9,  1'b0, STATUS_DONE,  4'd0,  4'd0));
    dir_rows.push_back(mk_row(REQ_INSERT, 4'd2,  1'b0, STATUS_DONE,  4'd0,  4'd0));
    dir_rows.push_back(mk_row(REQ_INSERT, 4'd15, 1'b0, STATUS_DONE,  4'd0,  4'd0));
    dir_rows.push_back(mk_row(REQ_INSERT, 4'd15, 1'b0, STATUS_DONE,  4'd0,  4'd0));
    dir_rows.push_back(mk_row(REQ_INSERT, 4'd0,  1'b0, STATUS_DONE,  4'd0,  4'd0));
    dir_rows.push_back(mk_row(REQ_INSERT, 4'd4,  1'b0, STATUS_DONE,  4'd0,  4'd0));
    dir_rows.push_back(mk_row(REQ_INSERT, 4'd6,  1'b1, STATUS_FULL,  4'd0,  4'd8));
    dir_rows.push_back(mk_row(REQ_INSERT, 4'd15, 1'b1, STATUS_FULL,  4'd0,  4'd8));
    for (int k = 0; k < DEPTH; k++) begin
      dir_rows.push_back(mk_row(REQ_REMOVE, 4'(k * 2 + 1), 1'b0, STATUS_DONE, 4'd0, 4'd0));
    end
    dir_rows.push_back(mk_row(REQ_REMOVE, 4'd15, 1'b1, STATUS_EMPTY, 4'd0,  4'd0));

    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random part: phases that fill, drain or churn the queue, with values drawn
    // often from a narrow range so that equal maxima are common. The sender works
    // in bursts; the next word after a gap can arrive during a remove's scan.
    mix        = MIX_CHURN;
    mix_left   = 0;
    burst_left = 0;
    for (int n = 0; n < RAND_WORDS; n++) begin
      if (mix_left == 0) begin
        mix      = mix_t'($urandom_range(2));
        mix_left = $urandom_range(10, 40);
      end
      mix_left--;

      if (burst_left == 0) begin
        gap = $urandom_range(6);
        if (gap != 0) begin
          start = 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst_left = ($urandom_range(4) == 0) ? 60 : $urandom_range(1, 24);
      end
      burst_left--;

      pct = $urandom_range(99);
      case (mix)
        MIX_FILL:  go_insert = (pct < 80);
        MIX_DRAIN: go_insert = (pct < 20);
        default:   go_insert = (pct < 50);
      endcase
      w.req_type = go_insert ? REQ_INSERT : REQ_REMOVE;

      sel = $urandom_range(7);
      case (sel)
        0:       w.priority_req = 4'd0;
        1:       w.priority_req = 4'd15;
        2, 3:    w.priority_req = 4'($urandom_range(3));
        default: w.priority_req = 4'($urandom_range(15));
      endcase

      send_word(w, 1'b0, no_want);
    end
    start = 1'b0;

    // Wait for every expected result word, then let a full scan's worth of cycles
    // pass so that any stray word still shows up. The watchdog bounds the wait.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DEPTH + 4) @(posedge clk);

    if (err_count == 0) begin
      $display("array_priority_queue_extract_max_top_test: PASS");
    end else begin
      $display("array_priority_queue_extract_max_top_test: FAIL");
    end
    $finish;
  end

endmodule

[array_priority_queue_extract_max_top.f]
design/apq_pkg.sv
design/apq_cell.sv
design/array_priority_queue_extract_max_top.sv
tb/array_priority_queue_extract_max_top_test.sv
